>>> src/u16u8_pkg.sv
`timescale 1ns / 1ps

package u16u8_pkg;

	// job queue between front and back
	localparam int JOBQ_DEPTH = 4;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

	// utf-8 lead and continuation marks
	localparam logic [7:0] LEAD_TWO   = 8'hc0;
	localparam logic [7:0] LEAD_THREE = 8'he0;
	localparam logic [7:0] CONT_MARK  = 8'h80;
	localparam logic [5:0] CONT_MASK  = 6'h3f;

	// number of utf-8 bytes a nonzero unit needs
	typedef enum logic [1:0] {
		ENC_NONE  = 2'd0,
		ENC_ONE   = 2'd1,
		ENC_TWO   = 2'd2,
		ENC_THREE = 2'd3
	} enc_kind_t;

	// one classified unit handed from front to back
	typedef struct packed {
		logic [15:0] unit;
		enc_kind_t   kind;
		logic        term;
	} job_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} jobq_stat_t;

	// results a job produces: encoded bytes plus optional terminator
	function automatic logic [2:0] job_total(input job_t j);
		logic [2:0] n;
		n = {1'b0, j.kind} + {2'b00, j.term};
		return n;
	endfunction

endpackage

>>> src/u16u8_front.sv
`timescale 1ns / 1ps

module u16u8_front import u16u8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] data_byte,
	input  logic       buffer_last,
	input  jobq_stat_t q_stat,
	output logic       full,
	output logic       job_push,
	output job_t       job
);

	logic [7:0]  low_hold_q;
	logic        have_low_q;
	logic        done_q;
	logic        accept;
	logic [15:0] unit;
	logic        done_next;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;
	assign unit   = {data_byte, low_hold_q};

	// classify the unit completed by this beat
	always_comb begin
		job.unit  = unit;
		job.kind  = ENC_NONE;
		job.term  = 1'b0;
		done_next = done_q;
		if (have_low_q && !done_q) begin
			if (unit == 16'h0000) begin
				job.term  = 1'b1;
				done_next = 1'b1;
			end else if (unit[15:7] == 9'd0) begin
				job.kind = ENC_ONE;
			end else if (unit[15:11] == 5'd0) begin
				job.kind = ENC_TWO;
			end else begin
				job.kind = ENC_THREE;
			end
		end
		// buffer end closes a string still open
		if (buffer_last && !done_next)
			job.term = 1'b1;
	end

	assign job_push = accept && ((job.kind != ENC_NONE) || job.term);

	// pairing and string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_hold_q <= 8'h00;
			have_low_q <= 1'b0;
			done_q     <= 1'b0;
		end else if (accept) begin
			if (buffer_last) begin
				low_hold_q <= 8'h00;
				have_low_q <= 1'b0;
				done_q     <= 1'b0;
			end else begin
				if (!have_low_q)
					low_hold_q <= data_byte;
				have_low_q <= !have_low_q;
				done_q     <= done_next;
			end
		end
	end

endmodule

>>> src/u16u8_jobq.sv
`timescale 1ns / 1ps

module u16u8_jobq import u16u8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_job,
	input  logic       pop,
	output job_t       head,
	output jobq_stat_t stat
);

	job_t               slot_q [JOBQ_DEPTH];
	logic [JOBQ_AW-1:0] wr_ptr_q;
	logic [JOBQ_AW-1:0] rd_ptr_q;
	logic [JOBQ_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (count_q == (JOBQ_AW+1)'(JOBQ_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + JOBQ_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + JOBQ_AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (JOBQ_AW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (JOBQ_AW+1)'(1);
		end
	end

endmodule

>>> src/u16u8_back.sv
`timescale 1ns / 1ps

module u16u8_back import u16u8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  jobq_stat_t q_stat,
	output logic       q_pop,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] utf8_byte,
	output logic       string_end,
	output logic       run_last
);

	logic [1:0] step_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       end_q;
	logic       last_q;
	logic       load;
	logic       last_step;
	logic [2:0] total;
	logic [7:0] byte_d;
	logic       end_d;

	assign total     = job_total(head);
	assign last_step = ({1'b0, step_q} == total - 3'd1);
	assign load      = !q_stat.empty && (!out_valid_q || pop);
	assign q_pop     = load && last_step;

	// pick the byte for the current step of the head job
	always_comb begin
		byte_d = 8'h00;
		end_d  = 1'b1;
		if ({1'b0, step_q} < {1'b0, head.kind}) begin
			end_d = 1'b0;
			unique case (head.kind)
				ENC_ONE:
					byte_d = head.unit[7:0];
				ENC_TWO:
					byte_d = (step_q == 2'd0) ? (LEAD_TWO | {3'b000, head.unit[10:6]})
						: (CONT_MARK | {2'b00, head.unit[5:0] & CONT_MASK});
				ENC_THREE: begin
					unique case (step_q)
						2'd0: byte_d = LEAD_THREE | {4'h0, head.unit[15:12]};
						2'd1: byte_d = CONT_MARK | {2'b00, head.unit[11:6] & CONT_MASK};
						default: byte_d = CONT_MARK | {2'b00, head.unit[5:0] & CONT_MASK};
					endcase
				end
				default:
					byte_d = 8'h00;
			endcase
		end
	end

	// step through the head job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
		end else if (load) begin
			step_q <= last_step ? 2'd0 : step_q + 2'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= byte_d;
			end_q  <= end_d;
			last_q <= last_step;
		end
	end

	assign empty      = !out_valid_q;
	assign utf8_byte  = byte_q;
	assign string_end = end_q;
	assign run_last   = last_q;

endmodule

>>> src/utf16le_to_utf8_stream_core.sv
`timescale 1ns / 1ps
// path: a beat that completes a unit writes its job into the job queue, then its bytes pass the output register
// back end: one result per cycle unless pop stalls; one to four results per unit
// the byte pairing front takes one beat per cycle until the four-entry job queue fills
// sustained input rate is set by the output side, which gives up to four results per two-byte unit
// reset: arst_n clears pairing state, job queue pointers and output valid flag at once
module utf16le_to_utf8_stream_core import u16u8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       buffer_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] utf8_byte,
	output logic       string_end,
	output logic       run_last
);

	jobq_stat_t q_stat;
	job_t       new_job;
	job_t       head_job;
	logic       job_push;
	logic       q_pop;

	u16u8_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.data_byte   (data_byte),
		.buffer_last (buffer_last),
		.q_stat      (q_stat),
		.full        (full),
		.job_push    (job_push),
		.job         (new_job)
	);

	u16u8_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (new_job),
		.pop      (q_pop),
		.head     (head_job),
		.stat     (q_stat)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.q_stat     (q_stat),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.utf8_byte  (utf8_byte),
		.string_end (string_end),
		.run_last   (run_last)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !q_stat.full)
		else $error("job pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job popped from empty queue");

	a_term_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && string_end) |-> (utf8_byte == 8'h00 && run_last))
		else $error("terminator not a zero byte closing its run");

	a_job_has_results: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (new_job.kind != ENC_NONE || new_job.term))
		else $error("empty job queued");
`endif

endmodule
